>>> rtl/core/mlr_pkg.sv
// Shared types for the midpoint line rasteriser.
package mlr_pkg;

  // Octant classes after the endpoints are ordered so that x does not fall.
  typedef enum logic [1:0] {
    OCT_SHALLOW_UP   = 2'd0,  // x major, y rises
    OCT_STEEP_UP     = 2'd1,  // y major, y rises
    OCT_STEEP_DOWN   = 2'd2,  // y major, y falls
    OCT_SHALLOW_DOWN = 2'd3   // x major, y falls
  } mlr_octant_t;

  // Input tuser codes.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

endpackage

>>> rtl/core/midpoint_line_rasterizer.sv
// Midpoint (Bresenham) line rasteriser, streaming in and out.
// Latency: a step word's pixel appears on out_* the cycle after acceptance.
// Throughput: one input word per cycle while in_tready is high; a start word yields no output word.
// The output register is the only buffer: in_tready drops only while it is full and stalled.
// Reset (rst_n low, synchronous) clears the line-active flag and the output valid.
// Line geometry and output payload registers are not reset; a start word loads them.
module midpoint_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input channel
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // tdata, low bit up: x_start, y_start, x_end, y_end, zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      in_tdata,
  // tuser: action (start / step)
  input  logic                                   in_tuser,
  // Output channel
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // tdata, low bit up: pixel_x, pixel_y, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      out_tdata,
  // tlast: last_pixel
  output logic                                   out_tlast
);

  import mlr_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int AB      = COORD_BITS + 2;   // step_a / step_b width
  localparam int DB      = COORD_BITS + 4;   // decision width
  localparam int OUT_W   = ((2*COORD_BITS+7)/8)*8;
  localparam int OUT_PAD = OUT_W - 2*COORD_BITS;

  // ---------------------------------------------------------------
  // Line state
  // ---------------------------------------------------------------
  logic                 active_r,   active_nxt;
  logic signed [CB-1:0] cur_x_r,    cur_x_nxt;
  logic signed [CB-1:0] cur_y_r,    cur_y_nxt;
  logic signed [CB-1:0] stop_x_r,   stop_x_nxt;
  logic signed [CB-1:0] stop_y_r,   stop_y_nxt;
  logic signed [DB-1:0] dec_r,      dec_nxt;
  logic signed [AB-1:0] step_a_r,   step_a_nxt;
  logic signed [AB-1:0] step_b_r,   step_b_nxt;
  mlr_octant_t          oct_r,      oct_nxt;

  // Output register
  logic                 out_vld_r,  out_vld_nxt;
  logic signed [CB-1:0] pix_x_r,    pix_x_nxt;
  logic signed [CB-1:0] pix_y_r,    pix_y_nxt;
  logic                 pix_last_r, pix_last_nxt;

  // ---------------------------------------------------------------
  // Handshake: accept whenever the output register is free or draining
  // ---------------------------------------------------------------
  logic in_acc;
  logic is_start;

  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign is_start  = (in_tuser == ACT_START);

  // ---------------------------------------------------------------
  // Start word: order endpoints, classify octant, seed decision
  // ---------------------------------------------------------------
  logic signed [CB-1:0] xs, ys, xe, ye;
  logic signed [CB-1:0] x0, y0, x1, y1;
  logic signed [CB:0]   dx, dy;     // dx >= 0 after the swap
  logic signed [AB-1:0] ini_a, ini_b;
  logic signed [DB-1:0] dx_e, dy_e;
  mlr_octant_t          ini_oct;
  logic signed [DB-1:0] ini_dec;

  assign xs = $signed(in_tdata[CB-1:0]);
  assign ys = $signed(in_tdata[2*CB-1:CB]);
  assign xe = $signed(in_tdata[3*CB-1:2*CB]);
  assign ye = $signed(in_tdata[4*CB-1:3*CB]);

  always_comb begin
    if (xs > xe) begin
      x0 = xe; y0 = ye; x1 = xs; y1 = ys;
    end else begin
      x0 = xs; y0 = ys; x1 = xe; y1 = ye;
    end
    dx    = (CB+1)'(x1) - (CB+1)'(x0);
    dy    = (CB+1)'(y1) - (CB+1)'(y0);
    ini_a = AB'(dy) <<< 1;
    ini_b = -(AB'(dx) <<< 1);
    dx_e  = DB'(dx);
    dy_e  = DB'(dy);
    // a = 2dy, b = -2dx: decisions reduce to small sums of dx and dy
    if (!dy[CB] && dy <= dx) begin
      ini_oct = OCT_SHALLOW_UP;
      ini_dec = (dy_e <<< 1) - dx_e;
    end else if (!dy[CB]) begin
      ini_oct = OCT_STEEP_UP;
      ini_dec = dy_e - (dx_e <<< 1);
    end else if (dy <= -dx) begin
      ini_oct = OCT_STEEP_DOWN;
      ini_dec = dy_e + (dx_e <<< 1);
    end else begin
      ini_oct = OCT_SHALLOW_DOWN;
      ini_dec = (dy_e <<< 1) + dx_e;
    end
  end

  // ---------------------------------------------------------------
  // Step word: last-pixel test and one midpoint update
  // ---------------------------------------------------------------
  logic                 is_last;
  logic signed [DB-1:0] a_e, b_e;
  logic signed [DB-1:0] add_major, add_minor;
  logic signed [CB-1:0] stp_x, stp_y;

  assign a_e = DB'(step_a_r);
  assign b_e = DB'(step_b_r);

  always_comb begin
    stp_x     = cur_x_r;
    stp_y     = cur_y_r;
    add_major = '0;
    add_minor = '0;
    is_last   = 1'b0;
    case (oct_r)
      OCT_SHALLOW_UP: begin
        is_last   = (cur_x_r == stop_x_r);
        stp_x     = cur_x_r + CB'(1);
        add_major = a_e;
        if (dec_r > 0) begin
          stp_y     = cur_y_r + CB'(1);
          add_minor = b_e;
        end
      end
      OCT_STEEP_UP: begin
        is_last   = (cur_y_r == stop_y_r);
        stp_y     = cur_y_r + CB'(1);
        add_major = b_e;
        if (dec_r < 0) begin
          stp_x     = cur_x_r + CB'(1);
          add_minor = a_e;
        end
      end
      OCT_STEEP_DOWN: begin
        is_last   = (cur_y_r == stop_y_r);
        stp_y     = cur_y_r - CB'(1);
        add_major = -b_e;
        if (dec_r > 0) begin
          stp_x     = cur_x_r + CB'(1);
          add_minor = a_e;
        end
      end
      default: begin
        is_last   = (cur_x_r == stop_x_r);
        stp_x     = cur_x_r + CB'(1);
        add_major = a_e;
        if (dec_r < 0) begin
          stp_y     = cur_y_r - CB'(1);
          add_minor = -b_e;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Next-state selection
  // ---------------------------------------------------------------
  always_comb begin
    active_nxt   = active_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    stop_x_nxt   = stop_x_r;
    stop_y_nxt   = stop_y_r;
    dec_nxt      = dec_r;
    step_a_nxt   = step_a_r;
    step_b_nxt   = step_b_r;
    oct_nxt      = oct_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    pix_x_nxt    = pix_x_r;
    pix_y_nxt    = pix_y_r;
    pix_last_nxt = pix_last_r;

    if (in_acc) begin
      if (is_start) begin
        // new line replaces any line in flight
        active_nxt = 1'b1;
        cur_x_nxt  = x0;
        cur_y_nxt  = y0;
        stop_x_nxt = x1;
        stop_y_nxt = y1;
        dec_nxt    = ini_dec;
        step_a_nxt = ini_a;
        step_b_nxt = ini_b;
        oct_nxt    = ini_oct;
      end else if (active_r) begin
        out_vld_nxt  = 1'b1;
        pix_x_nxt    = cur_x_r;
        pix_y_nxt    = cur_y_r;
        pix_last_nxt = is_last;
        if (is_last) begin
          active_nxt = 1'b0;
        end else begin
          cur_x_nxt = stp_x;
          cur_y_nxt = stp_y;
          dec_nxt   = dec_r + add_major + add_minor;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    stop_x_r   <= stop_x_nxt;
    stop_y_r   <= stop_y_nxt;
    dec_r      <= dec_nxt;
    step_a_r   <= step_a_nxt;
    step_b_r   <= step_b_nxt;
    oct_r      <= oct_nxt;
    pix_x_r    <= pix_x_nxt;
    pix_y_r    <= pix_y_nxt;
    pix_last_r <= pix_last_nxt;
  end

  // ---------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------
  assign out_tvalid = out_vld_r;
  assign out_tlast  = pix_last_r;
  generate
    if (OUT_PAD > 0) begin : g_pad
      assign out_tdata = {{OUT_PAD{1'b0}}, pix_y_r, pix_x_r};
    end else begin : g_nopad
      assign out_tdata = {pix_y_r, pix_x_r};
    end
  endgenerate

endmodule

>>> test/midpoint_line_rasterizer_tb.sv
// Stream testbench for the midpoint line rasteriser: directed table, then random lines.
`timescale 1ns / 1ps

module midpoint_line_rasterizer_tb;
  import mlr_pkg::*;

  localparam int COORD_BITS  = 12;
  localparam int IN_W        = ((4*COORD_BITS+7)/8)*8;
  localparam int OUT_W       = ((2*COORD_BITS+7)/8)*8;
  localparam int RANDOM_WORDS = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One plotted pixel as the block should present it.
  typedef struct {
    coord_t x;
    coord_t y;
    logic   last_px;
  } pixel_t;

  // Per-word note from the sender: a typed-in result overrides the predictor.
  typedef struct {
    bit     typed;
    bit     has_px;
    pixel_t px;
  } word_note_t;

  // Directed stimulus row; step rows leave the coordinates at zero.
  typedef struct {
    logic act;
    int   xs, ys, xe, ye;
    bit   typed;
    bit   has_px;
    int   ex, ey;
    bit   el;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;    // x_start, y_start, x_end, y_end
  logic             in_tuser = 1'b0;  // action
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;        // pixel_x, pixel_y
  logic             out_tlast;        // last_pixel

  midpoint_line_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // Pixels still owed by the block, oldest first, and the notes for words in flight.
  pixel_t     pixel_q[$];
  word_note_t word_notes[$];
  int         fault_count = 0;

  // Holds requested by the sender and served by the receiver.
  int holds_asked = 0;
  int holds_granted = 0;

  // ------------------------------------------------------------------------
  // Line tracker: own copy of the rasteriser state.
  // ------------------------------------------------------------------------
  logic                   line_active = 1'b0;
  coord_t                 line_x = '0, line_y = '0;
  coord_t                 line_stop_x = '0, line_stop_y = '0;
  logic signed [COORD_BITS+3:0] line_err = '0;   // decision value
  logic signed [COORD_BITS+1:0] line_a = '0;     // 2*dy
  logic signed [COORD_BITS+1:0] line_b = '0;     // -2*dx
  mlr_octant_t            line_oct = OCT_SHALLOW_UP;

  task automatic rasterise_word(input logic act, input coord_t xs, input coord_t ys,
                                input coord_t xe, input coord_t ye,
                                output bit emits, output pixel_t px);
    coord_t ax, ay, bx, by;
    int     da, db, d0;
    bit     ends;
    emits = 1'b0;
    px = '{'0, '0, 1'b0};
    if (act == ACT_START) begin
      // order endpoints so that x never falls
      if (xs > xe) begin
        ax = xe; ay = ye; bx = xs; by = ys;
      end else begin
        ax = xs; ay = ys; bx = xe; by = ye;
      end
      da = 2 * (int'(by) - int'(ay));
      db = -2 * (int'(bx) - int'(ax));
      if (da >= 0 && da <= -db) begin
        line_oct = OCT_SHALLOW_UP;   d0 = da + db / 2;
      end else if (da >= 0) begin
        line_oct = OCT_STEEP_UP;     d0 = da / 2 + db;
      end else if (da <= db) begin
        line_oct = OCT_STEEP_DOWN;   d0 = da / 2 - db;
      end else begin
        line_oct = OCT_SHALLOW_DOWN; d0 = da - db / 2;
      end
      line_a = da[COORD_BITS+1:0];
      line_b = db[COORD_BITS+1:0];
      line_err = d0[COORD_BITS+3:0];
      line_x = ax;
      line_y = ay;
      line_stop_x = bx;
      line_stop_y = by;
      line_active = 1'b1;
      return;
    end
    if (!line_active) return;

    // x-major classes end on stop_x, y-major ones on stop_y
    if (line_oct == OCT_SHALLOW_UP || line_oct == OCT_SHALLOW_DOWN)
      ends = (line_x == line_stop_x);
    else
      ends = (line_y == line_stop_y);
    emits = 1'b1;
    px = '{line_x, line_y, ends};
    if (ends) begin
      line_active = 1'b0;
      return;
    end
    case (line_oct)
      OCT_SHALLOW_UP: begin
        if (line_err > 0) begin
          line_y = line_y + 1;
          line_err = line_err + line_b;
        end
        line_x = line_x + 1;
        line_err = line_err + line_a;
      end
      OCT_STEEP_UP: begin
        if (line_err < 0) begin
          line_x = line_x + 1;
          line_err = line_err + line_a;
        end
        line_y = line_y + 1;
        line_err = line_err + line_b;
      end
      OCT_STEEP_DOWN: begin
        if (line_err > 0) begin
          line_x = line_x + 1;
          line_err = line_err + line_a;
        end
        line_y = line_y - 1;
        line_err = line_err - line_b;
      end
      default: begin
        if (line_err < 0) begin
          line_y = line_y - 1;
          line_err = line_err - line_b;
        end
        line_x = line_x + 1;
        line_err = line_err + line_a;
      end
    endcase
  endtask

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endtask

  // ------------------------------------------------------------------------
  // Scoreboard: input side first, then output side, in one process so that
  // a word accepted at an edge is predicted before any check at that edge.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    word_note_t nt;
    bit         emits;
    pixel_t     px, want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        nt = word_notes.pop_front();
        rasterise_word(in_tuser,
                       in_tdata[COORD_BITS-1:0],
                       in_tdata[2*COORD_BITS-1:COORD_BITS],
                       in_tdata[3*COORD_BITS-1:2*COORD_BITS],
                       in_tdata[4*COORD_BITS-1:3*COORD_BITS],
                       emits, px);
        if (nt.typed) begin
          emits = nt.has_px;
          px = nt.px;
        end
        if (emits) pixel_q.push_back(px);
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[COORD_BITS-1:0], out_tdata[2*COORD_BITS-1:COORD_BITS], out_tlast};
        if (pixel_q.size() == 0) begin
          log_fault($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                              got.x, got.y, got.last_px));
        end else begin
          want = pixel_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.last_px !== want.last_px)
            log_fault($sformatf("pixel mismatch: expected (%0d,%0d) last=%0b, got (%0d,%0d) last=%0b",
                                want.x, want.y, want.last_px, got.x, got.y, got.last_px));
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: rotating stall pattern, re-chosen each time pat_age reaches zero, plus long
  // hold-offs on request so that the output register fills and in_tready drops.
  // ------------------------------------------------------------------------
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_age = 0;
  int          hold_left = 0;

  always @(posedge clk) begin : receiver
    logic [15:0] next_pat;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      next_pat = stall_pat;
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0: next_pat = 16'hFFFF;                // no stalls at all
          1: next_pat = 16'($urandom);
          2: next_pat = 16'($urandom | $urandom);  // light
          default: next_pat = 16'($urandom & $urandom); // heavy
        endcase
      end
      pat_age <= (pat_age == 0) ? 63 : pat_age - 1;
      out_tready <= next_pat[0];
      stall_pat <= {next_pat[0], next_pat[15:1]};
    end
  end

  // Run limit; a hung block ends up here.
  int cycle_count = 0;
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Sender: words go out in bursts of random length with random gaps.
  // in_tvalid stays high from one word to the next inside a burst.
  // ------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_word(input logic act, input coord_t xs, input coord_t ys,
                           input coord_t xe, input coord_t ye, input word_note_t nt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    word_notes.push_back(nt);
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= IN_W'({ye, xe, ys, xs});
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // Pause the sender until every owed pixel has come out or the bound is reached.
  task automatic wait_for_drain(input int bound);
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (pixel_q.size() != 0 && n < bound);
  endtask

  function automatic coord_t near_coord(input coord_t base, input int span);
    int off, v;
    off = $urandom_range(0, 2*span);
    v = base + off - span;
    // reflect back inside the screen rather than wrap
    if (v > 2**(COORD_BITS-1) - 1 || v < -(2**(COORD_BITS-1))) v = base - (off - span);
    return coord_t'(v);
  endfunction

  int words_counted = 0;

  // One random line: start word then steps. Most lines run to their end;
  // some are cut short by the next start, some get stray steps after the end.
  task automatic random_line();
    coord_t     xs, ys, xe, ye;
    int         span, dx, dy, len, steps;
    word_note_t nt;
    nt = '{1'b0, 1'b0, '{'0, '0, 1'b0}};
    xs = coord_t'($urandom);
    ys = coord_t'($urandom);
    if ($urandom_range(0, 15) == 0) begin
      xe = coord_t'($urandom);
      ye = coord_t'($urandom);
    end else begin
      case ($urandom_range(0, 15))
        0:       span = 0;
        1,2,3,4: span = 40;
        default: span = 8;
      endcase
      xe = near_coord(xs, span);
      ye = near_coord(ys, span);
    end
    dx = int'(xe) - int'(xs);
    dy = int'(ye) - int'(ys);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    len = ((dx > dy) ? dx : dy) + 1;
    steps = len;
    case ($urandom_range(0, 7))
      0: steps = $urandom_range(0, len - 1);      // dropped by the next start
      1: steps = len + $urandom_range(1, 3);      // stray steps, no pixels
      default: ;
    endcase
    // long lines are mostly cut short to keep the run brief
    if (len > 64 && $urandom_range(0, 3) != 0) steps = $urandom_range(0, 64);
    // a long line never runs far past the word budget
    if (steps > 64 && steps > RANDOM_WORDS - words_counted) steps = 64;
    send_word(ACT_START, xs, ys, xe, ye, nt);
    words_counted += 1 + ((steps < len) ? steps : len);
    repeat (steps)
      send_word(ACT_STEP, coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom), nt);
  endtask

  // ------------------------------------------------------------------------
  // Directed table. Typed rows: reset state, extremes, single-pixel line.
  // Other rows are left to the line tracker.
  // ------------------------------------------------------------------------
  row_t dir_rows [0:24];

  initial begin : stimulus
    word_note_t nt;
    row_t       r;
    bit         paused;
    dir_rows = '{
      //  act        xs     ys     xe     ye  typed has   ex     ey  last
      '{ACT_STEP,      0,     0,     0,     0, 1, 0,     0,     0, 0}, // no line yet
      '{ACT_START,     5,    -7,     5,    -7, 1, 0,     0,     0, 0}, // equal endpoints
      '{ACT_STEP,      0,     0,     0,     0, 1, 1,     5,    -7, 1},
      '{ACT_STEP,      0,     0,     0,     0, 1, 0,     0,     0, 0}, // line over
      '{ACT_START, -2048, -2048,  2047,  2047, 1, 0,     0,     0, 0},
      '{ACT_STEP,      0,     0,     0,     0, 1, 1, -2048, -2048, 0},
      '{ACT_START,  2047, -2048, -2048,  2047, 1, 0,     0,     0, 0}, // restart, swapped
      '{ACT_STEP,      0,     0,     0,     0, 1, 1, -2048,  2047, 0},
      '{ACT_START,     0,     0,     2,     1, 0, 0,     0,     0, 0}, // shallow rising
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_START,    -3,     5,    -2,     7, 0, 0,     0,     0, 0}, // steep rising
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_START,     1,    -2,     0,     0, 0, 0,     0,     0, 0}, // steep falling, swapped
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_START,    12,     2,    10,     3, 0, 0,     0,     0, 0}, // shallow falling, swapped
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0},
      '{ACT_STEP,      0,     0,     0,     0, 0, 0,     0,     0, 0}  // after the end
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      nt = '{r.typed, r.has_px, '{coord_t'(r.ex), coord_t'(r.ey), r.el}};
      send_word(r.act, coord_t'(r.xs), coord_t'(r.ys), coord_t'(r.xe), coord_t'(r.ye), nt);
    end

    paused = 1'b0;
    while (words_counted < RANDOM_WORDS) begin
      random_line();
      // long receiver hold-offs while words keep coming
      if ((holds_asked == 0 && words_counted >= 600) ||
          (holds_asked == 1 && words_counted >= 1500))
        holds_asked++;
      // one full stop of the sender mid-run
      if (!paused && words_counted >= 1100) begin
        paused = 1'b1;
        wait_for_drain(CYCLE_LIMIT);
      end
    end

    // let the block settle after the last owed pixel
    wait_for_drain(20000);
    repeat (8) @(posedge clk);
    if (pixel_q.size() != 0)
      log_fault($sformatf("%0d pixels never arrived", pixel_q.size()));

    if (fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mlr_pkg.sv
rtl/core/midpoint_line_rasterizer.sv
test/midpoint_line_rasterizer_tb.sv
